// ===== rtl/slcp_pkg.sv =====
// Shared types and widths for the skew line closest point block.
// No dependencies; every rtl module imports this package.
`timescale 1ns / 1ps
`default_nettype none

package slcp_pkg;

  localparam int CW      = 16;
  localparam int DIFF_W  = CW + 1;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int MIX_W   = 54;
  localparam int PSQ_W   = 70;
  localparam int NA_W    = 72;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_REJECT   = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
    logic signed [CW-1:0] d_x;
    logic signed [CW-1:0] d_y;
    logic signed [CW-1:0] d_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [31:0] mid_z;
    logic [31:0]        gap;
    logic [31:0]        point_distance;
  } out_t;

  typedef struct packed {
    status_t                   status;
    logic [MIX_W-1:0]          mix;
    logic [PSQ_W-1:0]          psq;
    logic [NA_W-1:0]           na;
    logic [NA_W-1:0]           nb;
    logic [2:0][CW-1:0]        pa;
    logic [2:0][CW-1:0]        pb;
    logic [2:0][CW-1:0]        pc;
    logic [2:0][CW-1:0]        pd;
    logic [2:0][DIFF_W-1:0]    d1;
    logic [2:0][DIFF_W-1:0]    d2;
  } work_t;

endpackage

`default_nettype wire

// ===== rtl/skew_line_closest_point.sv =====
// Top level: closest points of two 3D lines given by point pairs.
// Depends on slcp_pkg, slcp_front, slcp_queue and slcp_back.
//
//   channel   handshake         payload           notes
//   input     push / full       pair   (in_t)     a,b,c,d coordinates
//   result    pop / empty       result (out_t)    status, midpoint, gap, distance
//   config    cfg_we            cfg_data          distance enable, no read-back
//
// One pair enters per cycle while full is low; the depth comes from the one-bit
// stages of the gap division (64), its square root (32) and the distance path.
// Reset is synchronous; the enable register clears to 0 and all words are dropped.
// The back end holds while a result waits unpopped; the queue then fills and
// full rises, holding the front end.
`timescale 1ns / 1ps
`default_nettype none

module skew_line_closest_point import slcp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  pair,
  output logic full,
  input  logic pop,
  output logic empty,
  output out_t result,
  input  logic cfg_we,
  input  logic cfg_data
);

  logic  q_push, q_full, q_pop, q_empty;
  work_t q_in, q_out;

  slcp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pair   (pair),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_word (q_in)
  );

  slcp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_out)
  );

  slcp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_empty  (q_empty),
    .q_word   (q_out),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

`default_nettype wire

// ===== rtl/slcp_front.sv =====
// Front end: takes a line pair, forms directions, cross and dot products, classifies.
// Depends on slcp_pkg; feeds slcp_queue.
`timescale 1ns / 1ps
`default_nettype none

module slcp_front import slcp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  in_t   pair,
  output logic  full,
  input  logic  q_full,
  output logic  q_push,
  output work_t q_word
);

  typedef struct packed {
    logic [2:0][CW-1:0]     pa;
    logic [2:0][CW-1:0]     pb;
    logic [2:0][CW-1:0]     pc;
    logic [2:0][CW-1:0]     pd;
    logic [2:0][DIFF_W-1:0] d1;
    logic [2:0][DIFF_W-1:0] d2;
    logic [2:0][DIFF_W-1:0] mm;
  } f1_t;

  typedef struct packed {
    logic [2:0][CW-1:0]      pa;
    logic [2:0][CW-1:0]      pb;
    logic [2:0][CW-1:0]      pc;
    logic [2:0][CW-1:0]      pd;
    logic [2:0][DIFF_W-1:0]  d1;
    logic [2:0][DIFF_W-1:0]  d2;
    logic [2:0][DIFF_W-1:0]  mm;
    logic [2:0][CROSS_W-1:0] p;
    logic [2:0][CROSS_W-1:0] t1;
    logic [2:0][CROSS_W-1:0] t2;
  } f2_t;

  function automatic logic signed [CROSS_W-1:0] mul_d(logic [DIFF_W-1:0] x,
                                                      logic [DIFF_W-1:0] y);
    logic signed [CROSS_W-1:0] xs;
    logic signed [CROSS_W-1:0] ys;
    xs = CROSS_W'($signed(x));
    ys = CROSS_W'($signed(y));
    return xs * ys;
  endfunction

  function automatic logic [2:0][CROSS_W-1:0] cross_d(logic [2:0][DIFF_W-1:0] u,
                                                      logic [2:0][DIFF_W-1:0] v);
    logic [2:0][CROSS_W-1:0] o;
    o[0] = mul_d(u[1], v[2]) - mul_d(u[2], v[1]);
    o[1] = mul_d(u[2], v[0]) - mul_d(u[0], v[2]);
    o[2] = mul_d(u[0], v[1]) - mul_d(u[1], v[0]);
    return o;
  endfunction

  function automatic logic [MIX_W-1:0] dot_pm(logic [2:0][CROSS_W-1:0] u,
                                              logic [2:0][DIFF_W-1:0] v);
    logic signed [MIX_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc = acc + MIX_W'($signed(u[i])) * MIX_W'($signed(v[i]));
    end
    return acc;
  endfunction

  function automatic logic [NA_W-1:0] dot_pp(logic [2:0][CROSS_W-1:0] u,
                                             logic [2:0][CROSS_W-1:0] v);
    logic signed [NA_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc = acc + NA_W'($signed(u[i])) * NA_W'($signed(v[i]));
    end
    return acc;
  endfunction

  logic  v1, v2, v3;
  logic  fen;
  f1_t   f1, f1_next;
  f2_t   f2;
  work_t w3;
  logic [NA_W-1:0] psq_full;
  logic [NA_W-1:0] nb_pos;

  assign fen    = !v3 || !q_full;
  assign full   = !fen;
  assign q_push = v3 && !q_full;
  assign q_word = w3;

  always_comb begin
    f1_next.pa = {pair.a_z, pair.a_y, pair.a_x};
    f1_next.pb = {pair.b_z, pair.b_y, pair.b_x};
    f1_next.pc = {pair.c_z, pair.c_y, pair.c_x};
    f1_next.pd = {pair.d_z, pair.d_y, pair.d_x};
    for (int i = 0; i < 3; i++) begin
      f1_next.d1[i] = DIFF_W'($signed(f1_next.pb[i])) - DIFF_W'($signed(f1_next.pa[i]));
      f1_next.d2[i] = DIFF_W'($signed(f1_next.pd[i])) - DIFF_W'($signed(f1_next.pc[i]));
      f1_next.mm[i] = DIFF_W'($signed(f1_next.pd[i])) - DIFF_W'($signed(f1_next.pb[i]));
    end
  end

  assign psq_full = dot_pp(f2.p, f2.p);
  assign nb_pos   = dot_pp(f2.t2, f2.p);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (fen) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1 <= f1_next;
      f2.pa <= f1.pa;
      f2.pb <= f1.pb;
      f2.pc <= f1.pc;
      f2.pd <= f1.pd;
      f2.d1 <= f1.d1;
      f2.d2 <= f1.d2;
      f2.mm <= f1.mm;
      f2.p  <= cross_d(f1.d1, f1.d2);
      f2.t1 <= cross_d(f1.mm, f1.d2);
      f2.t2 <= cross_d(f1.d1, f1.mm);
      w3.mix <= dot_pm(f2.p, f2.mm);
      w3.psq <= psq_full[PSQ_W-1:0];
      w3.na  <= dot_pp(f2.t1, f2.p);
      w3.nb  <= NA_W'(-$signed(nb_pos));
      w3.pa  <= f2.pa;
      w3.pb  <= f2.pb;
      w3.pc  <= f2.pc;
      w3.pd  <= f2.pd;
      w3.d1  <= f2.d1;
      w3.d2  <= f2.d2;
      if (f2.p == '0) begin
        w3.status <= ST_PARALLEL;
      end else if (dot_pm(f2.p, f2.mm) == '0) begin
        w3.status <= ST_REJECT;
      end else begin
        w3.status <= ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slcp_queue.sv =====
// Short word queue between front and back end.
// Depends on slcp_pkg for the work word type and depth.
`timescale 1ns / 1ps
`default_nettype none

module slcp_queue import slcp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output work_t rdata
);

  work_t           mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push, do_pop;

  assign full    = count == (Q_AW + 1)'(Q_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW + 1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    Q_AW'(wr_ptr - rd_ptr) == count[Q_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/slcp_back.sv =====
// Back end: midpoint, gap and point distance through pipelined dividers and roots.
// Depends on slcp_pkg; reads words from slcp_queue.
`timescale 1ns / 1ps
`default_nettype none

module slcp_back import slcp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic  cfg_data,
  input  logic  q_empty,
  input  work_t q_word,
  output logic  q_pop,
  input  logic  pop,
  output logic  empty,
  output out_t  result
);

  localparam int GSQ0  = 64;
  localparam int MFIN  = 32;
  localparam int DCR   = 33;
  localparam int DSQ   = 34;
  localparam int DSET  = 35;
  localparam int DDIV0 = 36;
  localparam int DSQ0  = 100;
  localparam int NSTEP = 132;

  typedef struct packed {
    status_t             status;
    logic [63:0]         mq_ll;
    logic [52:0]         mq_hl;
    logic [41:0]         mq_hh;
    logic [PSQ_W-1:0]    psq;
    logic [2:0][CW-1:0]  pa;
    logic [2:0][CW-1:0]  pc;
    logic [2:0][53:0]    e0l;
    logic [2:0][53:0]    e0h;
    logic [2:0][53:0]    e1l;
    logic [2:0][53:0]    e1h;
    logic [2:0][53:0]    e2l;
    logic [2:0][53:0]    e2h;
  } p1_t;

  typedef struct packed {
    status_t             status;
    logic [103:0]        mixsq;
    logic [PSQ_W-1:0]    psq;
    logic [2:0][CW-1:0]  pa;
    logic [2:0][CW-1:0]  pc;
    logic [2:0][89:0]    num;
  } p2_t;

  typedef struct packed {
    status_t             status;
    logic [PSQ_W-1:0]    psq;
    logic [70:0]         den;
    logic [69:0]         g_r;
    logic [63:0]         g_n;
    logic [63:0]         g_q;
    logic                g_ovf;
    logic [33:0]         gs_r;
    logic [31:0]         gs_res;
    logic [2:0][70:0]    m_r;
    logic [2:0][31:0]    m_n;
    logic [2:0][31:0]    m_q;
    logic [2:0]          m_neg;
    logic [2:0]          m_ovf;
    logic [2:0][31:0]    mid;
    logic [2:0][CW-1:0]  pa;
    logic [2:0][CW-1:0]  pc;
    logic [2:0][49:0]    cr;
    logic [65:0]         c_ll;
    logic [51:0]         c_hl;
    logic [37:0]         c_hh;
    logic [35:0]         acsq;
    logic [35:0]         d_r;
    logic [63:0]         d_n;
    logic [63:0]         d_q;
    logic                d_ovf;
    logic                d_zero;
    logic [33:0]         ds_r;
    logic [31:0]         ds_res;
  } bk_t;

  function automatic bk_t setup(p2_t s);
    bk_t        o;
    logic [89:0] an;
    o = '0;
    o.status = s.status;
    o.psq    = s.psq;
    o.den    = {s.psq, 1'b0};
    o.pa     = s.pa;
    o.pc     = s.pc;
    o.g_ovf  = {30'b0, s.mixsq[103:64]} >= s.psq;
    o.g_r    = {30'b0, s.mixsq[103:64]};
    o.g_n    = s.mixsq[63:0];
    for (int i = 0; i < 3; i++) begin
      o.m_neg[i] = s.num[i][89];
      an = s.num[i][89] ? 90'(-$signed(s.num[i])) : s.num[i];
      o.m_ovf[i] = {13'b0, an[89:32]} >= o.den;
      o.m_r[i]   = {13'b0, an[89:32]};
      o.m_n[i]   = an[31:0];
    end
    return o;
  endfunction

  function automatic bk_t step(bk_t s, int k);
    bk_t                o;
    logic [70:0]        gr2;
    logic [71:0]        mr2;
    logic [36:0]        dr2;
    logic [35:0]        r4;
    logic [33:0]        tq;
    logic [33:0]        qq;
    logic signed [32:0] ma [3];
    logic signed [50:0] mw [3];
    logic signed [50:0] aw [3];
    logic signed [50:0] crs [3];
    logic signed [16:0] ac [3];
    logic [103:0]       csum;
    logic [65:0]        ll;
    logic [51:0]        hl;
    logic [37:0]        hh;
    logic [35:0]        asum;
    o = s;
    if (k < GSQ0) begin
      gr2 = {s.g_r, s.g_n[63]};
      o.g_n = {s.g_n[62:0], 1'b0};
      if (gr2 >= {1'b0, s.psq}) begin
        o.g_r = 70'(gr2 - {1'b0, s.psq});
        o.g_q = {s.g_q[62:0], 1'b1};
      end else begin
        o.g_r = gr2[69:0];
        o.g_q = {s.g_q[62:0], 1'b0};
      end
    end else if (k < GSQ0 + 32) begin
      r4  = {s.gs_r, s.g_q[63:62]};
      tq  = {s.gs_res, 2'b01};
      o.g_q = {s.g_q[61:0], 2'b00};
      if (r4 >= {2'b00, tq}) begin
        o.gs_r   = 34'(r4 - {2'b00, tq});
        o.gs_res = {s.gs_res[30:0], 1'b1};
      end else begin
        o.gs_r   = r4[33:0];
        o.gs_res = {s.gs_res[30:0], 1'b0};
      end
    end
    if (k < MFIN) begin
      for (int i = 0; i < 3; i++) begin
        mr2 = {s.m_r[i], s.m_n[i][31]};
        o.m_n[i] = {s.m_n[i][30:0], 1'b0};
        if (mr2 >= {1'b0, s.den}) begin
          o.m_r[i] = 71'(mr2 - {1'b0, s.den});
          o.m_q[i] = {s.m_q[i][30:0], 1'b1};
        end else begin
          o.m_r[i] = mr2[70:0];
          o.m_q[i] = {s.m_q[i][30:0], 1'b0};
        end
      end
    end else if (k == MFIN) begin
      for (int i = 0; i < 3; i++) begin
        qq = {2'b00, s.m_q[i]} + 34'(s.m_r[i] != '0 && s.m_neg[i]);
        if (s.m_ovf[i]) begin
          o.mid[i] = s.m_neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!s.m_neg[i] && qq > 34'h0_7FFF_FFFF) begin
          o.mid[i] = 32'h7FFF_FFFF;
        end else if (s.m_neg[i] && qq > 34'h0_8000_0000) begin
          o.mid[i] = 32'h8000_0000;
        end else begin
          o.mid[i] = s.m_neg[i] ? 32'(-qq) : qq[31:0];
        end
      end
    end else if (k == DCR) begin
      for (int i = 0; i < 3; i++) begin
        ma[i] = 33'($signed(s.mid[i])) - 33'($signed(s.pa[i]));
        ac[i] = 17'($signed(s.pc[i])) - 17'($signed(s.pa[i]));
        mw[i] = 51'(ma[i]);
        aw[i] = 51'(ac[i]);
      end
      crs[0] = mw[1] * aw[2] - mw[2] * aw[1];
      crs[1] = mw[2] * aw[0] - mw[0] * aw[2];
      crs[2] = mw[0] * aw[1] - mw[1] * aw[0];
      for (int i = 0; i < 3; i++) begin
        o.cr[i] = crs[i][50] ? 50'(-crs[i]) : crs[i][49:0];
      end
    end else if (k == DSQ) begin
      ll   = '0;
      hl   = '0;
      hh   = '0;
      asum = '0;
      for (int i = 0; i < 3; i++) begin
        ac[i] = 17'($signed(s.pc[i])) - 17'($signed(s.pa[i]));
        ll = ll + 66'(s.cr[i][31:0]) * 66'(s.cr[i][31:0]);
        hl = hl + 52'(s.cr[i][49:32]) * 52'(s.cr[i][31:0]);
        hh = hh + 38'(s.cr[i][49:32]) * 38'(s.cr[i][49:32]);
        asum = asum + 36'(ac[i]) * 36'(ac[i]);
      end
      o.c_ll = ll;
      o.c_hl = hl;
      o.c_hh = hh;
      o.acsq = asum;
    end else if (k == DSET) begin
      csum = 104'({s.c_hh, 64'b0}) + 104'({s.c_hl, 33'b0}) + 104'(s.c_ll);
      o.d_ovf  = {csum[103:64]} >= {4'b0, s.acsq};
      o.d_zero = s.acsq == '0;
      o.d_r    = csum[99:64];
      o.d_n    = csum[63:0];
      o.d_q    = '0;
      o.ds_r   = '0;
      o.ds_res = '0;
    end else if (k >= DDIV0 && k < DSQ0) begin
      dr2 = {s.d_r, s.d_n[63]};
      o.d_n = {s.d_n[62:0], 1'b0};
      if (dr2 >= {1'b0, s.acsq}) begin
        o.d_r = 36'(dr2 - {1'b0, s.acsq});
        o.d_q = {s.d_q[62:0], 1'b1};
      end else begin
        o.d_r = dr2[35:0];
        o.d_q = {s.d_q[62:0], 1'b0};
      end
    end else if (k >= DSQ0) begin
      r4  = {s.ds_r, s.d_q[63:62]};
      tq  = {s.ds_res, 2'b01};
      o.d_q = {s.d_q[61:0], 2'b00};
      if (r4 >= {2'b00, tq}) begin
        o.ds_r   = 34'(r4 - {2'b00, tq});
        o.ds_res = {s.ds_res[30:0], 1'b1};
      end else begin
        o.ds_r   = r4[33:0];
        o.ds_res = {s.ds_res[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic out_t finish(bk_t s, logic dist_on);
    out_t o;
    o = '0;
    o.status = s.status;
    if (s.status == ST_OK) begin
      o.mid_x = s.mid[0];
      o.mid_y = s.mid[1];
      o.mid_z = s.mid[2];
      o.gap   = s.g_ovf ? 32'hFFFF_FFFF : s.gs_res;
      if (dist_on) begin
        o.point_distance = (s.d_zero || s.d_ovf) ? 32'hFFFF_FFFF : s.ds_res;
      end
    end
    return o;
  endfunction

  logic             distance_enable;
  logic             ben;
  logic             v1, v2, ovld;
  logic [NSTEP:0]   vld;
  p1_t              p1;
  p2_t              p2;
  bk_t              st [NSTEP+1];
  out_t             oword;
  logic [52:0]      amix;

  assign ben    = !ovld || pop;
  assign q_pop  = ben && !q_empty;
  assign empty  = !ovld;
  assign result = oword;
  assign amix   = q_word.mix[MIX_W-1] ? 53'(-$signed(q_word.mix)) : q_word.mix[52:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_enable <= 1'b0;
    end else if (cfg_we) begin
      distance_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      vld  <= '0;
      ovld <= 1'b0;
    end else if (ben) begin
      v1   <= !q_empty;
      v2   <= v1;
      vld  <= {vld[NSTEP-1:0], v2};
      ovld <= vld[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      p1.status <= q_word.status;
      p1.mq_ll  <= 64'(amix[31:0]) * 64'(amix[31:0]);
      p1.mq_hl  <= 53'(amix[52:32]) * 53'(amix[31:0]);
      p1.mq_hh  <= 42'(amix[52:32]) * 42'(amix[52:32]);
      p1.psq    <= q_word.psq;
      p1.pa     <= q_word.pa;
      p1.pc     <= q_word.pc;
      for (int i = 0; i < 3; i++) begin
        p1.e0l[i] <= 54'($signed({1'b0, q_word.psq[34:0]}))
                     * (54'($signed(q_word.pb[i])) + 54'($signed(q_word.pd[i])));
        p1.e0h[i] <= 54'($signed({1'b0, q_word.psq[69:35]}))
                     * (54'($signed(q_word.pb[i])) + 54'($signed(q_word.pd[i])));
        p1.e1l[i] <= 54'($signed({1'b0, q_word.na[35:0]})) * 54'($signed(q_word.d1[i]));
        p1.e1h[i] <= 54'($signed(q_word.na[71:36])) * 54'($signed(q_word.d1[i]));
        p1.e2l[i] <= 54'($signed({1'b0, q_word.nb[35:0]})) * 54'($signed(q_word.d2[i]));
        p1.e2h[i] <= 54'($signed(q_word.nb[71:36])) * 54'($signed(q_word.d2[i]));
      end
      p2.status <= p1.status;
      p2.mixsq  <= 104'({p1.mq_hh, 64'b0}) + 104'({p1.mq_hl, 33'b0}) + 104'(p1.mq_ll);
      p2.psq    <= p1.psq;
      p2.pa     <= p1.pa;
      p2.pc     <= p1.pc;
      for (int i = 0; i < 3; i++) begin
        p2.num[i] <= (90'($signed(p1.e0h[i])) <<< 35) + 90'($signed(p1.e0l[i]))
                   + (90'($signed(p1.e1h[i])) <<< 36) + 90'($signed(p1.e1l[i]))
                   + (90'($signed(p1.e2h[i])) <<< 36) + 90'($signed(p1.e2l[i]));
      end
      st[0] <= setup(p2);
      oword <= finish(st[NSTEP], distance_enable);
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (ben) begin
        st[k+1] <= step(st[k], k);
      end
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (ovld && oword.status != ST_OK) |->
      (oword.gap == '0 && oword.point_distance == '0 && oword.mid_x == '0))
    else $error("non-valid status carries payload");

  a_dist_off: assert property (@(posedge clk) disable iff (rst)
    (ovld && !distance_enable) |-> oword.point_distance == '0)
    else $error("point distance set while disabled");

endmodule

`default_nettype wire
